// ----- sv/mhw_pkg.sv -----
package mhw_pkg;

  localparam int NUM_CORES = 4;
  localparam int CORE_W    = 3;
  localparam int OP_W      = 3;
  localparam int TIME_W    = 32;
  localparam int MASK_W    = 8;
  localparam int ADDR_W    = 4;
  localparam int REG_IDX_W = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [TIME_W-1:0] U32_MAX = '1;

  localparam logic [OP_W-1:0] OP_MS_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_CHECK_IN  = 3'd1;
  localparam logic [OP_W-1:0] OP_HARD_TICK = 3'd2;
  localparam logic [OP_W-1:0] OP_WDT_IRQ   = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP      = 3'd4;

  localparam logic [REG_IDX_W-1:0] REG_BIND_THR  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_STALL_THR = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IRQ_PRES  = 2'd2;

  localparam logic [TIME_W-1:0] BIND_THR_RESET  = 32'd24000;
  localparam logic [TIME_W-1:0] STALL_THR_RESET = 32'd25500;

  typedef struct packed {
    logic [TIME_W-1:0] bind_threshold_ms;
    logic [TIME_W-1:0] stall_threshold_ms;
    logic              irq_present;
  } cfg_t;

  typedef struct packed {
    logic              force_reset;
    logic [MASK_W-1:0] hard_overdue;
    logic [MASK_W-1:0] soft_overdue;
    logic              stall_report;
    logic [CORE_W-1:0] bind_core;
    logic              bind_valid;
    logic              kick;
  } result_t;

endpackage

// ----- sv/mhw_cfg.sv -----
module mhw_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mhw_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output mhw_pkg::cfg_t              cfg
);

  logic [mhw_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          wr_en;

  assign reg_idx = paddr[mhw_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bind_threshold_ms  <= mhw_pkg::BIND_THR_RESET;
      cfg.stall_threshold_ms <= mhw_pkg::STALL_THR_RESET;
      cfg.irq_present        <= 1'b1;
    end else if (wr_en) begin
      case (reg_idx)
        mhw_pkg::REG_BIND_THR:  cfg.bind_threshold_ms  <= pwdata;
        mhw_pkg::REG_STALL_THR: cfg.stall_threshold_ms <= pwdata;
        mhw_pkg::REG_IRQ_PRES:  cfg.irq_present        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mhw_pkg::REG_BIND_THR:  prdata = cfg.bind_threshold_ms;
      mhw_pkg::REG_STALL_THR: prdata = cfg.stall_threshold_ms;
      mhw_pkg::REG_IRQ_PRES:  prdata = {31'd0, cfg.irq_present};
      default:                prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/mhw_core.sv -----
module mhw_core (
  input  logic                       clk,
  input  logic                       rst,
  input  mhw_pkg::cfg_t              cfg,
  input  logic                       fire,
  input  logic [mhw_pkg::OP_W-1:0]   opcode,
  input  logic [mhw_pkg::CORE_W-1:0] core_index,
  output mhw_pkg::result_t           res
);

  localparam int NC = mhw_pkg::NUM_CORES;
  localparam int TW = mhw_pkg::TIME_W;

  logic [TW-1:0]            elapsed_ms, elapsed_ms_next;
  logic [NC-1:0]            alive_mask, alive_mask_next;
  logic [TW-1:0]            soft_last [NC];
  logic [TW-1:0]            soft_last_next [NC];
  logic [TW-1:0]            hard_last [NC];
  logic [TW-1:0]            hard_last_next [NC];
  logic                     stopped, stopped_next;
  logic [mhw_pkg::CORE_W-1:0] irq_core, irq_core_next;

  logic                     core_ok;
  logic [NC-1:0]            sel;
  logic [NC-1:0]            alive_set;
  logic [TW-1:0]            oldest;
  logic [TW-1:0]            age;
  logic [TW-1:0]            hard_eff [NC];
  logic [mhw_pkg::MASK_W-1:0] soft_mask, hard_mask;
  logic                     do_report;

  function automatic logic [TW-1:0] age_of(input logic [TW-1:0] now,
                                           input logic [TW-1:0] last);
    age_of = (now >= last) ? (now - last) : '0;
  endfunction

  assign core_ok = ({1'b0, core_index} < (mhw_pkg::CORE_W+1)'(NC));

  always_comb begin
    for (int i = 0; i < NC; i++) begin
      sel[i] = core_ok && (core_index == mhw_pkg::CORE_W'(i));
    end
  end

  always_comb begin
    oldest = mhw_pkg::U32_MAX;
    for (int i = 0; i < NC; i++) begin
      if (soft_last[i] < oldest) oldest = soft_last[i];
    end
    age = age_of(elapsed_ms, oldest);
  end

  always_comb begin
    soft_mask = '0;
    hard_mask = '0;
    for (int i = 0; i < NC; i++) begin
      hard_eff[i] = (opcode == mhw_pkg::OP_HARD_TICK && sel[i]) ? elapsed_ms : hard_last[i];
      soft_mask[i] = age_of(elapsed_ms, soft_last[i]) >= cfg.stall_threshold_ms;
      hard_mask[i] = age_of(elapsed_ms, hard_eff[i]) >= cfg.stall_threshold_ms;
    end
  end

  assign alive_set = alive_mask | sel;

  always_comb begin
    elapsed_ms_next = elapsed_ms;
    alive_mask_next = alive_mask;
    soft_last_next  = soft_last;
    hard_last_next  = hard_last;
    stopped_next    = stopped;
    irq_core_next   = irq_core;
    do_report       = 1'b0;
    res             = '0;
    if (!stopped) begin
      case (opcode)
        mhw_pkg::OP_MS_TICK: begin
          if (elapsed_ms != mhw_pkg::U32_MAX) elapsed_ms_next = elapsed_ms + 1'b1;
        end
        mhw_pkg::OP_CHECK_IN: begin
          if (core_ok) begin
            if (&alive_set) begin
              alive_mask_next = '0;
              elapsed_ms_next = '0;
              for (int i = 0; i < NC; i++) begin
                soft_last_next[i] = '0;
                hard_last_next[i] = '0;
              end
              res.kick = 1'b1;
            end else begin
              alive_mask_next = alive_set;
              for (int i = 0; i < NC; i++) begin
                if (sel[i]) soft_last_next[i] = elapsed_ms;
              end
            end
          end
        end
        mhw_pkg::OP_HARD_TICK: begin
          if (core_ok) begin
            hard_last_next = hard_eff;
            if (age >= cfg.bind_threshold_ms && cfg.irq_present && irq_core != core_index) begin
              irq_core_next  = core_index;
              res.bind_valid = 1'b1;
            end
            if (!cfg.irq_present && age >= cfg.stall_threshold_ms) do_report = 1'b1;
          end
        end
        mhw_pkg::OP_WDT_IRQ: begin
          if (cfg.irq_present) do_report = 1'b1;
        end
        mhw_pkg::OP_STOP: begin
          elapsed_ms_next = '0;
          stopped_next    = 1'b1;
          res.kick        = 1'b1;
        end
        default: ;
      endcase
    end
    if (do_report) begin
      stopped_next     = 1'b1;
      res.stall_report = 1'b1;
      res.soft_overdue = soft_mask;
      res.hard_overdue = hard_mask;
      res.force_reset  = 1'b1;
    end
    res.bind_core = irq_core_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms <= '0;
      alive_mask <= '0;
      stopped    <= 1'b0;
      irq_core   <= '0;
      for (int i = 0; i < NC; i++) begin
        soft_last[i] <= '0;
        hard_last[i] <= '0;
      end
    end else if (fire) begin
      elapsed_ms <= elapsed_ms_next;
      alive_mask <= alive_mask_next;
      stopped    <= stopped_next;
      irq_core   <= irq_core_next;
      soft_last  <= soft_last_next;
      hard_last  <= hard_last_next;
    end
  end

endmodule

// ----- sv/multicore_heartbeat_watchdog.sv -----
// Heartbeat supervisor for four cores, with core masks eight bits wide. Each
// request on the slave stream (opcode in tuser, core index in tdata) yields
// exactly one result on the master stream. A request is registered on entry,
// processed against the supervisor state in a single pass and its result
// registered on exit, so one request is taken every cycle when the master
// side is not stalled. Thresholds and the interrupt presence flag sit on the
// APB port; the user must write them only while the stream is idle, and the
// block itself does not enforce this.
module multicore_heartbeat_watchdog (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [mhw_pkg::IN_DATA_W-1:0]  s_tdata,  // [2:0] core_index
  input  logic [mhw_pkg::OP_W-1:0]       s_tuser,  // [2:0] opcode
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] kick, [1] bind_valid, [4:2] bind_core, [5] stall_report,
  // [13:6] soft_overdue, [21:14] hard_overdue, [22] force_reset
  output logic [mhw_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mhw_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  mhw_pkg::cfg_t               cfg;
  mhw_pkg::result_t            res;
  logic                        in_valid;
  logic [mhw_pkg::OP_W-1:0]    in_opcode;
  logic [mhw_pkg::CORE_W-1:0]  in_core;
  logic                        advance;
  logic                        fire;

  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  mhw_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mhw_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (fire),
    .opcode     (in_opcode),
    .core_index (in_core),
    .res        (res)
  );

  // hold the request until the core stage takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_opcode <= s_tuser;
      in_core   <= s_tdata[mhw_pkg::CORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {1'b0, res};
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import mhw_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_ITEMS   = 320;
  localparam int GAP_PERCENT    = 8;
  localparam int CORE_TOP       = (1 << CORE_W) - 1;

  localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;

  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;
  typedef enum int {HALT_BY_STOP, HALT_BY_IRQ, HALT_BY_STALL} halt_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [OP_W-1:0]        op;
    logic [CORE_W-1:0]      core;
    bit                     typed;
    result_t                want;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic [31:0]            value;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  // supervisor mirror
  logic [TIME_W-1:0] ms_count;
  logic [MASK_W-1:0] checked_in;
  logic [TIME_W-1:0] soft_seen [NUM_CORES];
  logic [TIME_W-1:0] hard_seen [NUM_CORES];
  logic              halted;
  logic [CORE_W-1:0] irq_target;
  logic [TIME_W-1:0] cfg_bind_thr;
  logic [TIME_W-1:0] cfg_stall_thr;
  logic              cfg_irq_line;

  result_t    expected_results [$];
  row_t       script [$];
  int         errors = 0;
  int         cycle_count = 0;
  bit         gaps_on = 1'b1;
  halt_kind_t how;
  result_t    want_res;
  result_t    got_res;

  multicore_heartbeat_watchdog i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [TIME_W-1:0] age_since(input logic [TIME_W-1:0] last);
    return (ms_count >= last) ? ms_count - last : '0;
  endfunction

  function automatic logic [TIME_W-1:0] oldest_soft_age();
    logic [TIME_W-1:0] oldest;
    oldest = U32_MAX;
    for (int i = 0; i < NUM_CORES; i++) begin
      if (soft_seen[i] < oldest) oldest = soft_seen[i];
    end
    return age_since(oldest);
  endfunction

  function automatic void flag_stall(inout result_t r);
    for (int i = 0; i < NUM_CORES; i++) begin
      if (age_since(soft_seen[i]) >= cfg_stall_thr) r.soft_overdue[i] = 1'b1;
      if (age_since(hard_seen[i]) >= cfg_stall_thr) r.hard_overdue[i] = 1'b1;
    end
    halted = 1'b1;
    r.stall_report = 1'b1;
    r.force_reset = 1'b1;
  endfunction

  function automatic bit would_halt(input logic [OP_W-1:0] op, input logic [CORE_W-1:0] core);
    if (halted) return 1'b0;
    return op == OP_STOP || (op == OP_WDT_IRQ && cfg_irq_line) ||
           (op == OP_HARD_TICK && core < NUM_CORES && !cfg_irq_line &&
            oldest_soft_age() >= cfg_stall_thr);
  endfunction

  function automatic result_t supervise(input logic [OP_W-1:0] op,
                                        input logic [CORE_W-1:0] core);
    result_t           r;
    logic [TIME_W-1:0] age;
    r = '0;
    if (!halted) begin
      if (op == OP_MS_TICK) begin
        if (ms_count != U32_MAX) ms_count = ms_count + 1'b1;
      end else if (op == OP_CHECK_IN && core < NUM_CORES) begin
        checked_in[core] = 1'b1;
        if (&checked_in[NUM_CORES-1:0]) begin
          checked_in = '0;
          ms_count = '0;
          for (int i = 0; i < NUM_CORES; i++) begin
            soft_seen[i] = '0;
            hard_seen[i] = '0;
          end
          r.kick = 1'b1;
        end else begin
          soft_seen[core] = ms_count;
        end
      end else if (op == OP_HARD_TICK && core < NUM_CORES) begin
        hard_seen[core] = ms_count;
        age = oldest_soft_age();
        if (age >= cfg_bind_thr && cfg_irq_line && irq_target != core) begin
          irq_target = core;
          r.bind_valid = 1'b1;
        end
        if (!cfg_irq_line && age >= cfg_stall_thr) flag_stall(r);
      end else if (op == OP_WDT_IRQ && cfg_irq_line) begin
        flag_stall(r);
      end else if (op == OP_STOP) begin
        ms_count = '0;
        halted = 1'b1;
        r.kick = 1'b1;
      end
    end
    r.bind_core = irq_target;
    return r;
  endfunction

  function automatic row_t do_item(input logic [OP_W-1:0] op, input logic [CORE_W-1:0] core);
    row_t row;
    row = '{kind: ROW_ITEM, op: op, core: core, typed: 1'b0, want: '0, reg_idx: '0,
            value: '0};
    return row;
  endfunction

  function automatic row_t do_item_exp(input logic [OP_W-1:0] op,
                                       input logic [CORE_W-1:0] core,
                                       input logic kick, input logic bind_valid,
                                       input logic [CORE_W-1:0] bind_core);
    row_t row;
    row = do_item(op, core);
    row.typed = 1'b1;
    row.want.kick = kick;
    row.want.bind_valid = bind_valid;
    row.want.bind_core = bind_core;
    return row;
  endfunction

  function automatic row_t do_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    row_t row;
    row = do_item(OP_MS_TICK, '0);
    row.kind = ROW_WRITE;
    row.reg_idx = idx;
    row.value = value;
    return row;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  task automatic push_request(input logic [OP_W-1:0] op, input logic [CORE_W-1:0] core,
                              input bit typed, input result_t typed_res);
    result_t predicted;
    while (gaps_on && $urandom_range(0, 99) < GAP_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= IN_DATA_W'(core);
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    predicted = supervise(op, core);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = value;
    case (idx)
      REG_BIND_THR:  cfg_bind_thr = value;
      REG_STALL_THR: cfg_stall_thr = value;
      REG_IRQ_PRES: begin
        cfg_irq_line = value[0];
        readback = {31'b0, value[0]};
      end
      default: ;
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== readback) begin
      $display("%0t: register %0d expected %h got %h", $time, idx, readback, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count, input bit guarded);
    logic [OP_W-1:0]   op;
    logic [CORE_W-1:0] core;
    int                pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) op = OP_MS_TICK;
      else if (pick < 67) op = OP_CHECK_IN;
      else if (pick < 87) op = OP_HARD_TICK;
      else if (pick < 93) op = OP_WDT_IRQ;
      else if (pick < 97) op = OP_STOP;
      else op = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
      if ($urandom_range(0, 9) == 0) core = CORE_W'($urandom_range(NUM_CORES, CORE_TOP));
      else core = CORE_W'($urandom_range(0, NUM_CORES - 1));
      // keep the supervisor running until the final section
      if (guarded && would_halt(op, core)) op = OP_MS_TICK;
      push_request(op, core, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    m_tready <= !(gaps_on && $urandom_range(0, 99) < GAP_PERCENT);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none got %h", $time, m_tdata);
        errors++;
      end else begin
        want_res = expected_results.pop_front();
        got_res = result_t'(m_tdata[$bits(result_t)-1:0]);
        check_field("kick", 8'(want_res.kick), 8'(got_res.kick));
        check_field("bind_valid", 8'(want_res.bind_valid), 8'(got_res.bind_valid));
        check_field("bind_core", 8'(want_res.bind_core), 8'(got_res.bind_core));
        check_field("stall_report", 8'(want_res.stall_report), 8'(got_res.stall_report));
        check_field("soft_overdue", want_res.soft_overdue, got_res.soft_overdue);
        check_field("hard_overdue", want_res.hard_overdue, got_res.hard_overdue);
        check_field("force_reset", 8'(want_res.force_reset), 8'(got_res.force_reset));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[multicore_heartbeat_watchdog] ERROR");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    ms_count = '0;
    checked_in = '0;
    for (int i = 0; i < NUM_CORES; i++) begin
      soft_seen[i] = '0;
      hard_seen[i] = '0;
    end
    halted = 1'b0;
    irq_target = '0;
    cfg_bind_thr = BIND_THR_RESET;
    cfg_stall_thr = STALL_THR_RESET;
    cfg_irq_line = 1'b1;

    script.push_back(do_item_exp(OP_HARD_TICK, 0, 0, 0, 0));
    script.push_back(do_item_exp(OP_MS_TICK, 0, 0, 0, 0));
    script.push_back(do_item_exp(OP_CHECK_IN, 0, 0, 0, 0));
    script.push_back(do_item_exp(OP_CHECK_IN, 7, 0, 0, 0));
    script.push_back(do_item_exp(OP_HARD_TICK, 4, 0, 0, 0));
    script.push_back(do_item_exp(OP_RESERVED_LO, 0, 0, 0, 0));
    script.push_back(do_item_exp(OP_RESERVED_LO + 3'd1, 3, 0, 0, 0));
    script.push_back(do_item_exp(OP_RESERVED_HI, 7, 0, 0, 0));
    script.push_back(do_item_exp(OP_CHECK_IN, 1, 0, 0, 0));
    script.push_back(do_item_exp(OP_CHECK_IN, 2, 0, 0, 0));
    script.push_back(do_item_exp(OP_CHECK_IN, 3, 1, 0, 0));
    script.push_back(do_write(REG_IRQ_PRES, 32'd0));
    script.push_back(do_item_exp(OP_WDT_IRQ, 5, 0, 0, 0));
    script.push_back(do_write(REG_BIND_THR, 32'd0));
    script.push_back(do_write(REG_IRQ_PRES, 32'hFFFF_FFFF));
    script.push_back(do_item_exp(OP_HARD_TICK, 3, 0, 1, 3));
    script.push_back(do_item_exp(OP_HARD_TICK, 3, 0, 0, 3));
    script.push_back(do_item(OP_MS_TICK, 6));
    script.push_back(do_item_exp(OP_HARD_TICK, 0, 0, 1, 0));
    script.push_back(do_write(REG_BIND_THR, 32'hFFFF_FFFF));
    script.push_back(do_item(OP_MS_TICK, 1));
    script.push_back(do_item_exp(OP_HARD_TICK, 2, 0, 0, 0));
    script.push_back(do_write(REG_STALL_THR, 32'hFFFF_FFFF));
    script.push_back(do_write(REG_IRQ_PRES, 32'd0));
    script.push_back(do_item_exp(OP_HARD_TICK, 1, 0, 0, 0));
    script.push_back(do_item(OP_CHECK_IN, 2));
    script.push_back(do_item(OP_CHECK_IN, 2));
    script.push_back(do_item(OP_MS_TICK, 0));
    script.push_back(do_item(OP_CHECK_IN, 1));
    script.push_back(do_item(OP_CHECK_IN, 0));
    script.push_back(do_item_exp(OP_CHECK_IN, 3, 1, 0, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) reg_write(script[i].reg_idx, script[i].value);
      else push_request(script[i].op, script[i].core, script[i].typed, script[i].want);
    end

    reg_write(REG_BIND_THR, 32'd0);
    reg_write(REG_STALL_THR, 32'd0);
    reg_write(REG_IRQ_PRES, 32'd1);
    run_random(RANDOM_ITEMS, 1'b1);

    reg_write(REG_BIND_THR, $urandom_range(1, 12));
    reg_write(REG_STALL_THR, $urandom_range(1, 16));
    reg_write(REG_IRQ_PRES, 32'd0);
    run_random(RANDOM_ITEMS, 1'b1);

    reg_write(REG_BIND_THR, $urandom_range(2, 20));
    reg_write(REG_STALL_THR, $urandom_range(2, 20));
    reg_write(REG_IRQ_PRES, 32'd1);
    gaps_on = 1'b0;
    run_random(RANDOM_ITEMS, 1'b1);
    gaps_on = 1'b1;

    reg_write(REG_BIND_THR, 32'hFFFF_FFFF);
    reg_write(REG_STALL_THR, 32'hFFFF_FFFF);
    reg_write(REG_IRQ_PRES, $urandom);
    run_random(RANDOM_ITEMS, 1'b1);

    reg_write(REG_BIND_THR, $urandom);
    reg_write(REG_STALL_THR, $urandom);
    reg_write(REG_IRQ_PRES, $urandom);
    run_random(RANDOM_ITEMS, 1'b1);

    how = halt_kind_t'($urandom_range(HALT_BY_STOP, HALT_BY_STALL));
    case (how)
      HALT_BY_STOP: begin
        push_request(OP_STOP, CORE_W'($urandom_range(0, CORE_TOP)), 1'b0, '0);
      end
      HALT_BY_IRQ: begin
        reg_write(REG_STALL_THR, $urandom_range(0, 10));
        reg_write(REG_IRQ_PRES, 32'd1);
        repeat ($urandom_range(0, 15)) push_request(OP_MS_TICK, '0, 1'b0, '0);
        push_request(OP_WDT_IRQ, CORE_W'($urandom_range(0, CORE_TOP)), 1'b0, '0);
      end
      default: begin
        reg_write(REG_STALL_THR, $urandom_range(0, 6));
        reg_write(REG_IRQ_PRES, 32'd0);
        repeat (8) push_request(OP_MS_TICK, '0, 1'b0, '0);
        push_request(OP_HARD_TICK, CORE_W'($urandom_range(0, NUM_CORES - 1)), 1'b0, '0);
      end
    endcase
    run_random(20, 1'b0);

    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("[multicore_heartbeat_watchdog] OK");
    end else begin
      $display("[multicore_heartbeat_watchdog] ERROR");
    end
    $finish;
  end

endmodule
